// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, skipped while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/cksw_pkg.sv -----
// Shared types and constants for the color-key sprite writer
package cksw_pkg;

    localparam int MAX_SIDE_DEF = 512;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int COORD_W      = 10;
    localparam int PIX_W        = 16;
    localparam int ADDR_W       = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_PAGE   = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    localparam logic [COORD_W-1:0] RST_WIDTH  = 10'd16;
    localparam logic [COORD_W-1:0] RST_HEIGHT = 10'd16;
    localparam logic [PIX_W-1:0]   RST_KEY    = 16'hF81F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_MIRROR        = 3'd4,
        REG_KEY_COLOR     = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        B_CMD_COL  = 4'd0,
        B_XH0      = 4'd1,
        B_XL0      = 4'd2,
        B_XH1      = 4'd3,
        B_XL1      = 4'd4,
        B_CMD_PAGE = 4'd5,
        B_YH0      = 4'd6,
        B_YL0      = 4'd7,
        B_YH1      = 4'd8,
        B_YL1      = 4'd9,
        B_CMD_WR0  = 4'd10,
        B_CMD_WR1  = 4'd11,
        B_PH       = 4'd12,
        B_PL       = 4'd13
    } t_beat;

    // One opaque pixel, already placed on the screen
    typedef struct packed {
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] y;
        logic [PIX_W-1:0]  pix;
    } t_entry;

endpackage

// ----- hdl/cksw_front.sv -----
// Front end: config registers, sprite counters, key test and screen placement
module cksw_front
    import cksw_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_q_push,
    output t_entry                o_q_entry
);
    localparam int CW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SWR = $clog2(MAX_SIDE + 1) + 1;
    localparam int SW  = (SWR > COORD_W) ? SWR : COORD_W;

    logic [COORD_W-1:0] r_origin_x, r_origin_y, r_width, r_height;
    logic               r_mirror;
    logic [PIX_W-1:0]   r_key;
    logic [CW-1:0]      r_col, n_col, r_row, n_row;

    logic [SW-1:0]      w_eff, h_eff, w_ext, h_ext, col_inc, row_inc;
    logic [ADDR_W-1:0]  x, y;
    logic               clear;

    always_comb begin
        w_ext = SW'(r_width);
        h_ext = SW'(r_height);
        if (w_ext == '0)
            w_eff = SW'(1);
        else if (w_ext > SW'(MAX_SIDE))
            w_eff = SW'(MAX_SIDE);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = SW'(1);
        else if (h_ext > SW'(MAX_SIDE))
            h_eff = SW'(MAX_SIDE);
        else
            h_eff = h_ext;
    end

    always_comb begin
        col_inc = SW'(r_col) + SW'(1);
        row_inc = SW'(r_row) + SW'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = (row_inc >= h_eff) ? '0 : CW'(row_inc);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_comb begin
        if (r_mirror)
            x = ADDR_W'(r_origin_x) + ADDR_W'(w_eff) - ADDR_W'(1) - ADDR_W'(r_col);
        else
            x = ADDR_W'(r_origin_x) + ADDR_W'(r_col);
        y = ADDR_W'(r_origin_y) + ADDR_W'(r_row);
    end

    assign o_q_push      = i_accept && (i_pixel != r_key);
    assign o_q_entry.x   = x;
    assign o_q_entry.y   = y;
    assign o_q_entry.pix = i_pixel;

    // Any geometry write starts a new sprite
    always_comb begin
        clear = 1'b0;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X, REG_ORIGIN_Y, REG_SPRITE_WIDTH,
                REG_SPRITE_HEIGHT, REG_MIRROR: clear = 1'b1;
                default: clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_mirror   <= 1'b0;
            r_key      <= RST_KEY;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_ORIGIN_X:      r_origin_x <= i_cfg_data[COORD_W-1:0];
                    REG_ORIGIN_Y:      r_origin_y <= i_cfg_data[COORD_W-1:0];
                    REG_SPRITE_WIDTH:  r_width    <= i_cfg_data[COORD_W-1:0];
                    REG_SPRITE_HEIGHT: r_height   <= i_cfg_data[COORD_W-1:0];
                    REG_MIRROR:        r_mirror   <= i_cfg_data[0];
                    REG_KEY_COLOR:     r_key      <= i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (clear) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ----- hdl/cksw_queue.sv -----
// Short queue of placed pixels between front and back end
module cksw_queue
    import cksw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_not_empty,
    output t_entry o_entry
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_entry        r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full      = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_entry     = r_mem[r_rd];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/cksw_back.sv -----
// Back end: walks one placed pixel through its fourteen bus beats
module cksw_back
    import cksw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_not_empty,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_bus_byte,
    output logic       o_is_data,
    output logic       o_last
);
    t_entry r_cur;
    logic   r_busy;
    t_beat  r_beat;
    logic   done, load;

    assign done    = r_busy && i_pop && (r_beat == B_PL);
    // Refill on the same edge the final beat leaves
    assign load    = i_q_not_empty && (!r_busy || done);
    assign o_q_pop = load;
    assign o_empty = !r_busy;
    assign o_last  = (r_beat == B_PL);

    always_comb begin
        o_bus_byte = CMD_WRITE;
        o_is_data  = 1'b1;
        unique case (r_beat)
            B_CMD_COL: begin
                o_bus_byte = CMD_COLUMN;
                o_is_data  = 1'b0;
            end
            B_XH0, B_XH1: o_bus_byte = r_cur.x[15:8];
            B_XL0, B_XL1: o_bus_byte = r_cur.x[7:0];
            B_CMD_PAGE: begin
                o_bus_byte = CMD_PAGE;
                o_is_data  = 1'b0;
            end
            B_YH0, B_YH1: o_bus_byte = r_cur.y[15:8];
            B_YL0, B_YL1: o_bus_byte = r_cur.y[7:0];
            B_CMD_WR0, B_CMD_WR1: begin
                o_bus_byte = CMD_WRITE;
                o_is_data  = 1'b0;
            end
            B_PH: o_bus_byte = r_cur.pix[15:8];
            B_PL: o_bus_byte = r_cur.pix[7:0];
            default: begin
                o_bus_byte = CMD_WRITE;
                o_is_data  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load)
            r_cur <= i_q_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= B_CMD_COL;
        end else if (load) begin
            r_busy <= 1'b1;
            r_beat <= B_CMD_COL;
        end else if (done) begin
            r_busy <= 1'b0;
            r_beat <= B_CMD_COL;
        end else if (r_busy && i_pop) begin
            r_beat <= t_beat'(r_beat + 4'd1);
        end
    end

endmodule

// ----- hdl/color_key_sprite_writer_unit.sv -----
// An accepted opaque pixel enters the queue; the back end loads it when idle or on its
// final beat, then sends one bus beat per cycle while pop is high, fourteen per pixel,
// and the two-entry queue lets the front take pixels while the back end drains.
// Transparent pixels are taken at one per cycle while the queue has room.
// Reset (synchronous, low): registers to defaults, counters and queue cleared.
module color_key_sprite_writer_unit
    import cksw_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_bus_byte,
    output logic                  o_is_data,
    output logic                  o_last
);
    t_entry f_entry, q_entry;
    logic   f_push, q_full, q_not_empty, q_pop, accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    cksw_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_q_push    (f_push),
        .o_q_entry   (f_entry)
    );

    cksw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_entry     (f_entry),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_entry     (q_entry)
    );

    cksw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_bus_byte    (o_bus_byte),
        .o_is_data     (o_is_data),
        .o_last        (o_last)
    );

endmodule

// ----- hdl/cksw_checker.sv -----
// Port-level checks for the sprite writer, bound to the top level
`include "assert_macros.svh"

module cksw_checker
    import cksw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_bus_byte,
    input logic       o_is_data,
    input logic       o_last
);
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_bus_byte) && $stable(o_is_data) && $stable(o_last))
    `ASSERT_SAME(a_last_is_data, i_clk, i_rst_n, !empty && o_last, o_is_data)
    `ASSERT_SAME(a_cmd_code, i_clk, i_rst_n, !empty && !o_is_data, o_bus_byte == CMD_COLUMN || o_bus_byte == CMD_PAGE || o_bus_byte == CMD_WRITE)
    `ASSERT_NEXT(a_seq_unbroken, i_clk, i_rst_n, !empty && pop && !o_last, !empty)
    `ASSERT_NEXT(a_seq_start, i_clk, i_rst_n, !empty && pop && o_last, empty || (o_bus_byte == CMD_COLUMN && !o_is_data))

endmodule

bind color_key_sprite_writer_unit cksw_checker u_cksw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_bus_byte (o_bus_byte),
    .o_is_data  (o_is_data),
    .o_last     (o_last)
);

// ----- verif/sprite_bus_checker.sv -----
`timescale 1ns / 1ps
// Bus beat checker: tracks register writes and pixels, predicts display bus beats, compares them
module sprite_bus_checker
    import cksw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  logic                  full,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [7:0]            bus_byte,
    input  logic                  is_data,
    input  logic                  last,
    output int                    fail_count,
    output int                    beats_pending,
    output int                    beats_checked,
    output int                    opaque_pixels
);

    typedef struct packed {
        logic [7:0] value;
        logic       data_flag;
        logic       last_flag;
    } t_bus_beat;

    t_bus_beat bus_beats_due[$];

    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;
    logic               mirror_on;
    logic [PIX_W-1:0]   key_reg;
    logic [8:0]         col;
    logic [8:0]         row;

    // Saturate a programmed side to 1..MAX_SIDE
    function automatic logic [COORD_W-1:0] side_of(input logic [COORD_W-1:0] v);
        if (v == '0)
            return COORD_W'(1);
        if (v > COORD_W'(MAX_SIDE_DEF))
            return COORD_W'(MAX_SIDE_DEF);
        return v;
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_ORIGIN_X:      org_x = d[COORD_W-1:0];
            REG_ORIGIN_Y:      org_y = d[COORD_W-1:0];
            REG_SPRITE_WIDTH:  width_reg = d[COORD_W-1:0];
            REG_SPRITE_HEIGHT: height_reg = d[COORD_W-1:0];
            REG_MIRROR:        mirror_on = d[0];
            REG_KEY_COLOR: begin
                key_reg = d;
                return;
            end
            default: return;
        endcase
        // any geometry write starts a new sprite
        col = '0;
        row = '0;
    endfunction

    // Place one pixel on the screen, queue its beats if opaque, advance the counters
    function automatic void place_pixel(input logic [PIX_W-1:0] p);
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [ADDR_W-1:0]  x;
        logic [ADDR_W-1:0]  y;
        logic [7:0]         b;
        w = side_of(width_reg);
        h = side_of(height_reg);
        if (mirror_on)
            x = ADDR_W'(org_x) + ADDR_W'(w) - ADDR_W'(1) - ADDR_W'(col);
        else
            x = ADDR_W'(org_x) + ADDR_W'(col);
        y = ADDR_W'(org_y) + ADDR_W'(row);
        if (p != key_reg) begin
            opaque_pixels++;
            for (int k = int'(B_CMD_COL); k <= int'(B_PL); k++) begin
                case (t_beat'(k))
                    B_CMD_COL:             b = CMD_COLUMN;
                    B_XH0, B_XH1:          b = x[15:8];
                    B_XL0, B_XL1:          b = x[7:0];
                    B_CMD_PAGE:            b = CMD_PAGE;
                    B_YH0, B_YH1:          b = y[15:8];
                    B_YL0, B_YL1:          b = y[7:0];
                    B_CMD_WR0, B_CMD_WR1:  b = CMD_WRITE;
                    B_PH:                  b = p[15:8];
                    default:               b = p[7:0];
                endcase
                bus_beats_due.push_back('{
                    value:     b,
                    data_flag: !(t_beat'(k) inside {B_CMD_COL, B_CMD_PAGE, B_CMD_WR0, B_CMD_WR1}),
                    last_flag: (t_beat'(k) == B_PL)
                });
            end
        end
        if (COORD_W'(col) + COORD_W'(1) >= w) begin
            col = '0;
            if (COORD_W'(row) + COORD_W'(1) >= h)
                row = '0;
            else
                row = row + 9'd1;
        end else begin
            col = col + 9'd1;
        end
    endfunction

    always @(posedge clk) begin
        t_bus_beat seen;
        t_bus_beat want;
        if (!rst_n) begin
            org_x      = '0;
            org_y      = '0;
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            mirror_on  = 1'b0;
            key_reg    = RST_KEY;
            col        = '0;
            row        = '0;
            bus_beats_due.delete();
        end else begin
            // compare first: beats of a pixel accepted at this edge show up later
            if (pop && !empty) begin
                seen = '{value: bus_byte, data_flag: is_data, last_flag: last};
                if (bus_beats_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected bus beat: byte %02h data %b last %b",
                                 $realtime, seen.value, seen.data_flag, seen.last_flag);
                end else begin
                    want = bus_beats_due.pop_front();
                    beats_checked++;
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: bus beat mismatch: expected byte %02h data %b last %b, got byte %02h data %b last %b",
                                     $realtime, want.value, want.data_flag, want.last_flag,
                                     seen.value, seen.data_flag, seen.last_flag);
                    end
                end
            end
            if (cfg_we)
                write_register(cfg_index, cfg_data);
            if (push && !full)
                place_pixel(pixel);
        end
        beats_pending <= bus_beats_due.size();
    end

endmodule

// ----- verif/color_key_sprite_writer_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the color-key sprite writer: clock, reset, stimulus, handshakes and verdict
module color_key_sprite_writer_unit_test;
    import cksw_pkg::*;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int IDLE_PCT       = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 32;
    localparam int STALL_LIMIT    = 3000;
    localparam int RANDOM_PHASES  = 13;
    localparam int CALM_PHASE     = 3;
    localparam int HOLD_PHASE     = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  push        = 1'b0;
    logic [PIX_W-1:0]      i_pixel     = '0;
    logic                  pop         = 1'b0;
    logic                  full;
    logic                  empty;
    logic [7:0]            o_bus_byte;
    logic                  o_is_data;
    logic                  o_last;

    int fail_count;
    int beats_pending;
    int beats_checked;
    int opaque_pixels;
    int pixels_sent;
    int cfg_writes;
    int stall_cycles;
    bit calm;
    bit rx_hold_req;

    color_key_sprite_writer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_bus_byte  (o_bus_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

    sprite_bus_checker bus_check (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .cfg_we        (i_cfg_we),
        .cfg_index     (i_cfg_index),
        .cfg_data      (i_cfg_data),
        .push          (push),
        .full          (full),
        .pixel         (i_pixel),
        .empty         (empty),
        .pop           (pop),
        .bus_byte      (o_bus_byte),
        .is_data       (o_is_data),
        .last          (o_last),
        .fail_count    (fail_count),
        .beats_pending (beats_pending),
        .beats_checked (beats_checked),
        .opaque_pixels (opaque_pixels)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a beat", STALL_LIMIT);
            $display("** color_key_sprite_writer_unit: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random pop gaps, and one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Stop offering, wait for every predicted beat, then let the design settle
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (beats_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // Mostly tiny sprites so rows and frames wrap often; a few huge or saturating ones
    function automatic logic [CFG_DATA_W-1:0] pick_side();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return CFG_DATA_W'($urandom_range(1, 6));
        if (roll < 78)
            return '0;
        if (roll < 90)
            return CFG_DATA_W'($urandom_range(509, 515));
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] key);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return key;
        if (roll < 42)
            return key ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
        return PIX_W'($urandom);
    endfunction

    initial begin
        logic [PIX_W-1:0] key_now;
        int               n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: plain colors, the default key and a near miss
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(RST_KEY);
        send_pixel(16'h07E0);
        send_pixel(RST_KEY ^ 16'h0001);
        drain();

        // far corner, widest sprite, mirrored: first column lands at 1023 + 511
        write_reg(REG_ORIGIN_X, 16'hFFFF);
        write_reg(REG_ORIGIN_Y, 16'd1023);
        write_reg(REG_SPRITE_WIDTH, 16'd512);
        write_reg(REG_SPRITE_HEIGHT, 16'd1023);
        write_reg(REG_MIRROR, 16'hFFFF);
        write_reg(REG_KEY_COLOR, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
        drain();

        // zero width acts as one column, so every pixel starts a new row
        write_reg(REG_ORIGIN_X, 16'hFC00);
        write_reg(REG_ORIGIN_Y, 16'h0000);
        write_reg(REG_SPRITE_WIDTH, 16'h0000);
        write_reg(REG_SPRITE_HEIGHT, 16'd3);
        write_reg(REG_MIRROR, 16'hFFFE);
        write_reg(REG_KEY_COLOR, 16'hFFFF);
        send_pixel(16'h1234);
        send_pixel(16'hFFFF);
        send_pixel(16'hABCD);
        send_pixel(16'h5555);
        drain();

        // 3x2 mirrored sprite; spare indexes and a key change must not restart it
        write_reg(REG_ORIGIN_X, 16'd5);
        write_reg(REG_SPRITE_WIDTH, 16'd3);
        write_reg(REG_SPRITE_HEIGHT, 16'd2);
        write_reg(REG_MIRROR, 16'h0001);
        send_pixel(16'h0F0F);
        send_pixel(16'hF0F0);
        send_pixel(16'h3C3C);
        drain();
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h5A5A);
        write_reg(REG_KEY_COLOR, 16'h0001);
        send_pixel(16'h0001);
        send_pixel(16'hC3C3);
        send_pixel(16'h0002);
        send_pixel(16'h9999);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = (phase == CALM_PHASE);
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_ORIGIN_X, CFG_DATA_W'($urandom));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_ORIGIN_Y, CFG_DATA_W'($urandom));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_SPRITE_WIDTH, pick_side());
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_SPRITE_HEIGHT, pick_side());
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_MIRROR, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                          CFG_DATA_W'($urandom));
            key_now = PIX_W'($urandom);
            write_reg(REG_KEY_COLOR, key_now);
            // hold the receiver while the sender keeps pushing, so the input stalls
            if (phase == HOLD_PHASE)
                rx_hold_req = 1'b1;
            n = $urandom_range(25, 45);
            repeat (n) send_pixel(pick_pixel(key_now));
            drain();
        end
        calm = 1'b0;

        $display("covered %0d pixels (%0d opaque) across %0d register writes",
                 pixels_sent, opaque_pixels, cfg_writes);
        $display("%0d bus beats checked, %0d failures", beats_checked, fail_count);
        if (fail_count == 0 && beats_pending == 0)
            $display("** color_key_sprite_writer_unit: PASSED **");
        else
            $display("** color_key_sprite_writer_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cksw_pkg.sv
hdl/cksw_front.sv
hdl/cksw_queue.sv
hdl/cksw_back.sv
hdl/color_key_sprite_writer_unit.sv
hdl/cksw_checker.sv
verif/sprite_bus_checker.sv
verif/color_key_sprite_writer_unit_test.sv
